// File: hw/rtl/tse_pkg.sv
// Shared constants and types for the tone sweep effect sequencer.
package tse_pkg;

  localparam int FREQ_BITS  = 16;
  localparam int COUNT_BITS = 12;
  localparam int REP_BITS   = 8;
  localparam int MODE_BITS  = 2;
  localparam int LFSR_W     = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Divider widths: dividend holds diff*d or the noise word, divisor holds diff or steps.
  localparam int PROD_W    = FREQ_BITS + COUNT_BITS;
  localparam int NUM_W     = (PROD_W > LFSR_W) ? PROD_W : LFSR_W;
  localparam int DEN_W     = (FREQ_BITS > COUNT_BITS) ? FREQ_BITS : COUNT_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam int CFG_DW_FC = (FREQ_BITS > COUNT_BITS) ? FREQ_BITS : COUNT_BITS;
  localparam int CFG_DW    = (CFG_DW_FC > REP_BITS) ? CFG_DW_FC : REP_BITS;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FREQ     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FREQ    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 3'd5;

  localparam logic [MODE_BITS-1:0] MODE_NOISE  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FALL   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RISE   = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_SILENT = 2'd3;

  typedef struct packed {
    logic [MODE_BITS-1:0]  pattern_mode;
    logic [REP_BITS-1:0]   repeat_count;
    logic [FREQ_BITS-1:0]  low_freq;
    logic [FREQ_BITS-1:0]  high_freq;
    logic [COUNT_BITS-1:0] tone_ticks;
    logic [COUNT_BITS-1:0] gap_ticks;
  } cfg_t;

endpackage

// File: hw/rtl/tse_cfg_regs.sv
// Configuration register file of the tone sweep effect sequencer.
module tse_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we_i,
  input  logic [tse_pkg::CFG_IDX_W-1:0] index_i,
  input  logic [tse_pkg::CFG_DW-1:0]    wdata_i,
  output tse_pkg::cfg_t                 cfg_o
);
  import tse_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (we_i) begin
      unique case (index_i)
        REG_PATTERN_MODE: cfg_r.pattern_mode <= wdata_i[MODE_BITS-1:0];
        REG_REPEAT_COUNT: cfg_r.repeat_count <= wdata_i[REP_BITS-1:0];
        REG_LOW_FREQ:     cfg_r.low_freq     <= wdata_i[FREQ_BITS-1:0];
        REG_HIGH_FREQ:    cfg_r.high_freq    <= wdata_i[FREQ_BITS-1:0];
        REG_TONE_TICKS:   cfg_r.tone_ticks   <= wdata_i[COUNT_BITS-1:0];
        REG_GAP_TICKS:    cfg_r.gap_ticks    <= wdata_i[COUNT_BITS-1:0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: hw/rtl/tse_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all pitch patterns.
module tse_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [tse_pkg::NUM_W-1:0] dividend_i,
  input  logic [tse_pkg::DEN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [tse_pkg::NUM_W-1:0] quotient_o,
  output logic [tse_pkg::DEN_W-1:0] remainder_o
);
  import tse_pkg::*;

  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    trial     = {rem_r, quo_r[NUM_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});
    rem_nxt   = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      den_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done_o      = done_r;
  assign quotient_o  = quo_r;
  assign remainder_o = rem_r;

endmodule

// File: hw/rtl/tone_sweep_effect_sequencer.sv
// Top level: effect sequencer with tick counters, LFSR and pitch arithmetic control.
//
// Usage:
//   in_valid/in_ready carries one transaction per timer tick (in_start_req = 0) or
//   per start request (in_start_req = 1). Each accepted transaction yields exactly
//   one result transaction on out_valid/out_ready: out_tone_on, out_pitch_out and
//   out_effect_done.
//   cfg_we/cfg_index/cfg_wdata write the six registers: pattern mode, repeat count,
//   low and high frequency, tone ticks and gap ticks. Write only while idle.
// Flow:
//   A tone tick with a nonzero band passes from acceptance through a multiply state,
//   the shared restoring divider at one bit per cycle over its 28-bit dividend,
//   and a done state before out_valid. Every other transaction goes straight to the
//   done state. in_ready is high only while the sequencer is idle and rises with
//   out_valid: a new transaction is taken only after the last result is loaded.
// Reset: rst_n (synchronous) clears the config registers, stops any effect and seeds
//   the noise LFSR with 0xACE1.
// Stall: a result held by out_ready low stays in the output register; the next
//   transaction may be accepted and worked, and waits before the output register.
module tone_sweep_effect_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_start_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tone_on,
  output logic [tse_pkg::FREQ_BITS-1:0] out_pitch_out,
  output logic                          out_effect_done,
  input  logic                          cfg_we,
  input  logic [tse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tse_pkg::CFG_DW-1:0]    cfg_wdata
);
  import tse_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_TONE = 3'b010,
    PH_GAP  = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    phase_t                ph;
    logic [REP_BITS-1:0]   rc;
    logic [COUNT_BITS-1:0] tc;
  } trk_t;

  // Skip parts that are finished or empty.
  function automatic trk_t settle(trk_t s, cfg_t c);
    trk_t                  t;
    logic [COUNT_BITS-1:0] tl;
    t  = s;
    tl = (c.pattern_mode == MODE_SILENT) ? '0 : c.tone_ticks;
    if (t.ph == PH_TONE && t.tc >= tl) begin
      t.ph = PH_GAP;
      t.tc = '0;
    end
    if (t.ph == PH_GAP && t.tc >= c.gap_ticks) begin
      t.rc = t.rc + 1'b1;
      t.tc = '0;
      if (t.rc >= c.repeat_count || t.rc == '0) begin
        t.ph = PH_IDLE;
      end else if (tl != '0) begin
        t.ph = PH_TONE;
      end else if (c.gap_ticks != '0) begin
        t.ph = PH_GAP;
      end else begin
        t.ph = PH_IDLE;
      end
    end
    return t;
  endfunction

  cfg_t cfg;

  tse_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .we_i    (cfg_we),
    .index_i (cfg_index),
    .wdata_i (cfg_wdata),
    .cfg_o   (cfg)
  );

  state_t                state_r, state_nxt;
  trk_t                  trk_r, trk_nxt;
  logic [LFSR_W-1:0]     lfsr_r, lfsr_nxt;
  logic                  on_pend_r, on_pend_nxt;
  logic                  done_pend_r, done_pend_nxt;
  logic                  use_div_r, use_div_nxt;
  logic [FREQ_BITS-1:0]  pitch_pend_r, pitch_pend_nxt;
  logic [COUNT_BITS-1:0] d_r, d_nxt;

  logic                 out_valid_r;
  logic                 out_tone_on_r;
  logic [FREQ_BITS-1:0] out_pitch_r;
  logic                 out_done_r;

  logic                  in_acc;
  logic                  out_load;
  trk_t                  trk_s1, trk_s2, trk_st, trk_inc;
  logic [COUNT_BITS-1:0] tc_inc;
  logic                  band_ok;
  logic [FREQ_BITS-1:0]  diff;
  logic [COUNT_BITS-1:0] steps;
  logic [LFSR_W-1:0]     lfsr_step;
  logic [PROD_W-1:0]     prod;

  logic                 div_start;
  logic [NUM_W-1:0]     div_dividend;
  logic [DEN_W-1:0]     div_divisor;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;
  logic [DEN_W-1:0]     div_rem;
  logic [FREQ_BITS-1:0] q_floor, q_ceil, pitch_final;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign band_ok   = (cfg.high_freq > cfg.low_freq);
  assign diff      = cfg.high_freq - cfg.low_freq;
  assign steps     = (cfg.tone_ticks < COUNT_BITS'(2)) ? COUNT_BITS'(1)
                                                       : cfg.tone_ticks - 1'b1;
  assign lfsr_step = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);

  // Counter bookkeeping for one transaction.
  always_comb begin
    trk_s1  = settle(trk_r, cfg);
    tc_inc  = (trk_s1.tc == '1) ? trk_s1.tc : trk_s1.tc + 1'b1;  // saturates
    trk_inc = trk_s1;
    trk_inc.tc = tc_inc;
    trk_s2  = settle(trk_inc, cfg);
    trk_st  = '{ph: PH_TONE, rc: '0, tc: '0};
    if (cfg.repeat_count == '0) begin
      trk_st.ph = PH_IDLE;
    end else begin
      trk_st = settle(trk_st, cfg);
    end
  end

  always_comb begin
    trk_nxt        = trk_r;
    lfsr_nxt       = lfsr_r;
    on_pend_nxt    = on_pend_r;
    done_pend_nxt  = done_pend_r;
    use_div_nxt    = use_div_r;
    pitch_pend_nxt = pitch_pend_r;
    d_nxt          = d_r;
    state_nxt      = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          on_pend_nxt    = 1'b0;
          done_pend_nxt  = 1'b0;
          use_div_nxt    = 1'b0;
          pitch_pend_nxt = '0;
          d_nxt          = trk_s1.tc;
          state_nxt      = ST_DONE;
          if (in_start_req) begin
            trk_nxt = trk_st;
          end else if (trk_s1.ph == PH_IDLE) begin
            trk_nxt = trk_s1;
          end else begin
            trk_nxt       = trk_s2;
            done_pend_nxt = (trk_s2.ph == PH_IDLE);
            if (trk_s1.ph == PH_TONE) begin
              on_pend_nxt = 1'b1;
              if (band_ok) begin
                use_div_nxt = 1'b1;
                state_nxt   = ST_MUL;
                if (cfg.pattern_mode == MODE_NOISE) begin
                  lfsr_nxt = lfsr_step;
                end
              end else begin
                pitch_pend_nxt = cfg.low_freq;
              end
            end
          end
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Divider operands; the product is registered inside the divider.
  assign prod         = PROD_W'(diff) * PROD_W'(d_r);
  assign div_start    = (state_r == ST_MUL);
  assign div_dividend = (cfg.pattern_mode == MODE_NOISE) ? NUM_W'(lfsr_r) : NUM_W'(prod);
  assign div_divisor  = (cfg.pattern_mode == MODE_NOISE) ? DEN_W'(diff) : DEN_W'(steps);

  tse_divider u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    q_floor = FREQ_BITS'(div_quo);
    q_ceil  = q_floor + FREQ_BITS'(div_rem != '0);
    case (cfg.pattern_mode)
      MODE_NOISE: pitch_final = cfg.low_freq + FREQ_BITS'(div_rem);
      MODE_FALL:  pitch_final = cfg.high_freq - q_ceil;
      default:    pitch_final = cfg.low_freq + q_floor;
    endcase
    if (!use_div_r) begin
      pitch_final = pitch_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      trk_r       <= '{ph: PH_IDLE, rc: '0, tc: '0};
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      trk_r   <= trk_nxt;
      lfsr_r  <= lfsr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    on_pend_r    <= on_pend_nxt;
    done_pend_r  <= done_pend_nxt;
    use_div_r    <= use_div_nxt;
    pitch_pend_r <= pitch_pend_nxt;
    d_r          <= d_nxt;
    if (out_load) begin
      out_tone_on_r <= on_pend_r;
      out_pitch_r   <= pitch_final;
      out_done_r    <= done_pend_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tone_on     = out_tone_on_r;
  assign out_pitch_out   = out_pitch_r;
  assign out_effect_done = out_done_r;

endmodule
